// File: rtl/utf8v_pkg.sv
// shared types and constants of the utf-8 text validator
package utf8v_pkg;

   localparam int unsigned ByteWidth = 8;

   // lead and continuation byte boundaries
   localparam logic [ByteWidth-1:0] AsciiMax     = 8'h7f;
   localparam logic [ByteWidth-1:0] Lead2Min     = 8'hc2;
   localparam logic [ByteWidth-1:0] Lead2Max     = 8'hdf;
   localparam logic [ByteWidth-1:0] Lead3Min     = 8'he0;
   localparam logic [ByteWidth-1:0] Lead3Max     = 8'hef;
   localparam logic [ByteWidth-1:0] Lead4Min     = 8'hf0;
   localparam logic [ByteWidth-1:0] Lead4Max     = 8'hf4;
   localparam logic [ByteWidth-1:0] LeadSurr     = 8'hed;
   localparam logic [ByteWidth-1:0] ContMask     = 8'hc0;
   localparam logic [ByteWidth-1:0] ContTag      = 8'h80;
   localparam logic [ByteWidth-1:0] Limit3       = 8'ha0;
   localparam logic [ByteWidth-1:0] Limit4       = 8'h90;

   // forbidden characters
   localparam logic [ByteWidth-1:0] CharNul      = 8'h00;
   localparam logic [ByteWidth-1:0] CharLf       = 8'h0a;
   localparam logic [ByteWidth-1:0] CharCr       = 8'h0d;
   localparam logic [ByteWidth-1:0] CharSpace    = 8'h20;

   // limit on the byte right after a lead
   typedef enum logic [2:0] {
      RULE_NONE   = 3'd0,
      RULE_MIN_A0 = 3'd1,
      RULE_LT_A0  = 3'd2,
      RULE_MIN_90 = 3'd3,
      RULE_LT_90  = 3'd4
   } rule_type;

   typedef struct packed {
      logic [1:0] pending;
      rule_type   rule;
      logic       err;
   } seq_state_type;

   localparam seq_state_type SeqStateClear = '{pending: 2'd0, rule: RULE_NONE, err: 1'b0};

   typedef struct packed {
      logic          has_result;
      logic          valid_res;
      seq_state_type next_state;
   } step_out_type;

endpackage

// File: rtl/utf8_text_validator_core.sv
// top level of the strict utf-8 text validator
//
// usage: a string enters on the req_ channel one byte per item; req_last marks
// the final byte, and an item with req_empty_marker set ends an empty string
// (its byte is ignored). one item leaves on the rsp_ channel per string, with
// rsp_valid_res high only if every byte passed and no sequence was left open.
// order: an accepted item sits in the input register, is checked from there,
// and its result is loaded into the result register, which drives rsp_.
// throughput: one item per cycle unless a string-ending item waits on a full result
// register; six state flops and byte compares sit between input and result registers.
// stall: the result register holds until rsp_ready; while it is full, bytes
// that end no string still flow through, and a string-ending item waits in the
// input register, which then drops req_ready.
// reset: synchronous, clears both registers' valid flags and the sequence
// state; no clearing pass is needed and the block is ready the cycle after.
module utf8_text_validator_core
   import utf8v_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [ByteWidth-1:0] req_text_byte,
   input  logic                 req_last,
   input  logic                 req_empty_marker,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_valid_res
);

   // input register
   logic                 s1_valid_ff, s1_valid_in;
   logic [ByteWidth-1:0] s1_byte_ff;
   logic                 s1_last_ff;
   logic                 s1_empty_ff;

   // running sequence state of the current string
   seq_state_type        state_ff, state_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_valid_res_ff;

   step_out_type         step_out;
   logic                 out_free;
   logic                 s1_advance;
   logic                 req_take;

   utf8v_step u_step (
      .cur_state    (state_ff),
      .text_byte    (s1_byte_ff),
      .last         (s1_last_ff),
      .empty_marker (s1_empty_ff),
      .step_out     (step_out)
   );

   // result slot is free when empty or being drained this cycle
   assign out_free   = ~rsp_valid_ff | rsp_ready;
   // items that end no string never wait on the result side
   assign s1_advance = s1_valid_ff & (~step_out.has_result | out_free);
   assign req_ready  = ~s1_valid_ff | s1_advance;
   assign req_take   = req_valid & req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      if (s1_advance) begin
         state_in = step_out.next_state;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance && step_out.has_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= SeqStateClear;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff  <= req_text_byte;
         s1_last_ff  <= req_last;
         s1_empty_ff <= req_empty_marker;
      end
      if (s1_advance && step_out.has_result) begin
         rsp_valid_res_ff <= step_out.valid_res;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_valid_res = rsp_valid_res_ff;

endmodule

// File: rtl/utf8v_step.sv
// combinational check of one byte against the running sequence state
module utf8v_step
   import utf8v_pkg::*;
(
   input  seq_state_type        cur_state,
   input  logic [ByteWidth-1:0] text_byte,
   input  logic                 last,
   input  logic                 empty_marker,
   output step_out_type         step_out
);

   seq_state_type upd;

   always_comb begin
      upd = cur_state;
      if (text_byte == CharNul || text_byte == CharLf ||
          text_byte == CharCr || text_byte == CharSpace) begin
         upd.err = 1'b1;
      end
      if (cur_state.pending == 2'd0) begin
         upd.rule = RULE_NONE;
         priority if (text_byte <= AsciiMax) begin
            upd.pending = 2'd0;
         end else if (text_byte >= Lead2Min && text_byte <= Lead2Max) begin
            upd.pending = 2'd1;
         end else if (text_byte >= Lead3Min && text_byte <= Lead3Max) begin
            upd.pending = 2'd2;
            if (text_byte == Lead3Min) begin
               upd.rule = RULE_MIN_A0;
            end else if (text_byte == LeadSurr) begin
               upd.rule = RULE_LT_A0;
            end
         end else if (text_byte >= Lead4Min && text_byte <= Lead4Max) begin
            upd.pending = 2'd3;
            if (text_byte == Lead4Min) begin
               upd.rule = RULE_MIN_90;
            end else if (text_byte == Lead4Max) begin
               upd.rule = RULE_LT_90;
            end
         end else begin
            upd.err = 1'b1;
         end
      end else begin
         if ((text_byte & ContMask) != ContTag) begin
            upd.err = 1'b1;
         end
         unique case (cur_state.rule)
            RULE_MIN_A0: if (text_byte < Limit3)  upd.err = 1'b1;
            RULE_LT_A0:  if (text_byte >= Limit3) upd.err = 1'b1;
            RULE_MIN_90: if (text_byte < Limit4)  upd.err = 1'b1;
            RULE_LT_90:  if (text_byte >= Limit4) upd.err = 1'b1;
            default: ;
         endcase
         upd.rule    = RULE_NONE;
         upd.pending = cur_state.pending - 2'd1;
      end
   end

   always_comb begin
      step_out.has_result = last | empty_marker;
      step_out.valid_res  = ~empty_marker & ~upd.err & (upd.pending == 2'd0);
      step_out.next_state = (last | empty_marker) ? SeqStateClear : upd;
   end

endmodule

// File: rtl/utf8v_checker.sv
// port-level checker for the utf-8 text validator and its bind
module utf8v_checker
   import utf8v_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic [ByteWidth-1:0] req_text_byte,
   input logic                 req_last,
   input logic                 req_empty_marker,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_valid_res
);

   // no result right after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // waiting input item holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=>
         req_valid && $stable({req_text_byte, req_last, req_empty_marker}))
      else $error("waiting input item changed");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_valid_res))
      else $error("stalled result changed");

   // a new result traces back to an accepted string-ending item
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |->
         $past(req_valid && req_ready && (req_last || req_empty_marker), 2))
      else $error("result without a string-ending item");

   // empty strings are never valid
   a_empty_invalid: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) && $past(req_valid && req_ready && req_empty_marker, 2)
         |-> !rsp_valid_res)
      else $error("empty string reported valid");

endmodule

bind utf8_text_validator_core utf8v_checker u_utf8v_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_text_byte    (req_text_byte),
   .req_last         (req_last),
   .req_empty_marker (req_empty_marker),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_valid_res    (rsp_valid_res)
);
